@@ hw/rtl/differential_drive_odometry_assert.svh @@
// ----------------------------------------------------------------------------
// Odometry assertion macros
// Shorthand for clocked assertions on clk_i with reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH

// same-cycle implication
`define ODO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("odometry check failed");

// next-cycle implication
`define ODO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("odometry check failed");

`endif

@@ hw/rtl/ddo_pkg.sv @@
// ----------------------------------------------------------------------------
// Odometry package
// Shared widths, fixed-point constants, control types and helper functions.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 24;

  localparam logic [31:0] MPT_RESET = 32'd1898790;
  localparam logic [31:0] IBW_RESET = 32'd71393260;

  // serial multiplier: A operand, B operand (one bit a cycle), product
  localparam int unsigned MUL_AW = 55;
  localparam int unsigned MUL_BW = 32;
  localparam int unsigned MUL_PW = MUL_AW + MUL_BW;

  // serial divider: left-aligned dividend, divisor, bit count
  localparam int unsigned DIV_NW = 73;
  localparam int unsigned DIV_DW = 37;
  localparam int unsigned DIV_LW = $clog2(DIV_NW + 1);

  localparam logic signed [33:0] PI_Q29           = 34'sd1686629713;
  localparam logic signed [33:0] TWO_PI_Q29       = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q29      = 34'sd843314856;
  localparam logic signed [33:0] CORDIC_START_Q30 = 34'sd652032874;
  localparam logic [31:0]        US_PER_SECOND    = 32'd1000000;

  typedef struct packed {
    logic              start;
    logic [DIV_LW-1:0] len;
  } ddo_div_ctl_t;

  function automatic logic [30:0] atan_q30(input logic [4:0] idx);
    logic [30:0] r;
    case (idx)
      5'd0:    r = 31'd843314856;
      5'd1:    r = 31'd497837829;
      5'd2:    r = 31'd263043836;
      5'd3:    r = 31'd133525158;
      5'd4:    r = 31'd67021686;
      5'd5:    r = 31'd33543515;
      5'd6:    r = 31'd16775850;
      5'd7:    r = 31'd8388437;
      5'd8:    r = 31'd4194282;
      5'd9:    r = 31'd2097149;
      5'd10:   r = 31'd1048575;
      5'd11:   r = 31'd524287;
      5'd12:   r = 31'd262143;
      5'd13:   r = 31'd131071;
      5'd14:   r = 31'd65535;
      5'd15:   r = 31'd32767;
      5'd16:   r = 31'd16383;
      5'd17:   r = 31'd8191;
      5'd18:   r = 31'd4095;
      5'd19:   r = 31'd2047;
      5'd20:   r = 31'd1023;
      5'd21:   r = 31'd511;
      5'd22:   r = 31'd255;
      5'd23:   r = 31'd127;
      5'd24:   r = 31'd63;
      5'd25:   r = 31'd31;
      5'd26:   r = 31'd15;
      5'd27:   r = 31'd7;
      5'd28:   r = 31'd3;
      5'd29:   r = 31'd1;
      default: r = 31'd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat34(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -34'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] rate_sat(input logic neg, input logic ovf,
                                           input logic [31:0] q);
    logic [31:0] r;
    if (ovf || q[31]) begin
      r = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = neg ? 32'(-q) : q;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/ddo_mul.sv @@
// ----------------------------------------------------------------------------
// Odometry serial multiplier
// Unsigned shift-add multiplier, one bit of the B operand per cycle.
// ----------------------------------------------------------------------------
module ddo_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ddo_pkg::MUL_AW-1:0]   a_i,
  input  logic [ddo_pkg::MUL_BW-1:0]   b_i,
  output logic [ddo_pkg::MUL_PW-1:0]   prod_o,
  output logic                         done_o
);
  import ddo_pkg::*;

  localparam int unsigned MCW = $clog2(MUL_BW + 1);

  logic [MUL_AW-1:0] a_q;
  logic [MUL_AW-1:0] hi_q, hi_d;
  logic [MUL_BW-1:0] lo_q, lo_d;
  logic [MCW-1:0]    cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [MUL_AW:0]   sum;

  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

  always_comb begin
    hi_d   = hi_q;
    lo_d   = lo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      hi_d  = '0;
      lo_d  = b_i;
      cnt_d = MCW'(MUL_BW);
    end else if (cnt_q != '0) begin
      hi_d   = sum[MUL_AW:1];
      lo_d   = {sum[0], lo_q[MUL_BW-1:1]};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == MCW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
    end
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign prod_o = {hi_q, lo_q};
  assign done_o = done_q;

endmodule

@@ hw/rtl/ddo_div.sv @@
// ----------------------------------------------------------------------------
// Odometry serial divider
// Restoring divider, one quotient bit per cycle, with quotient overflow flag.
// ----------------------------------------------------------------------------
module ddo_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ddo_pkg::ddo_div_ctl_t       ctl_i,
  input  logic [ddo_pkg::DIV_NW-1:0]  n_i,
  input  logic [ddo_pkg::DIV_DW-1:0]  d_i,
  output logic [31:0]                 q_o,
  output logic                        ovf_o,
  output logic [ddo_pkg::DIV_DW-1:0]  rem_o,
  output logic                        done_o
);
  import ddo_pkg::*;

  logic [DIV_NW-1:0] n_q, n_d;
  logic [DIV_DW-1:0] d_q;
  logic [DIV_DW-1:0] rem_q, rem_d;
  logic [31:0]       q_q, q_d;
  logic              ovf_q, ovf_d;
  logic [DIV_LW-1:0] cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [DIV_DW:0]   trial, trial_sub;
  logic              ge;

  assign trial     = {rem_q, n_q[DIV_NW-1]};
  assign ge        = (trial >= {1'b0, d_q});
  assign trial_sub = trial - {1'b0, d_q};

  always_comb begin
    n_d    = n_q;
    rem_d  = rem_q;
    q_d    = q_q;
    ovf_d  = ovf_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (ctl_i.start) begin
      n_d   = n_i;
      rem_d = '0;
      q_d   = '0;
      ovf_d = 1'b0;
      cnt_d = ctl_i.len;
    end else if (cnt_q != '0) begin
      n_d    = {n_q[DIV_NW-2:0], 1'b0};
      rem_d  = ge ? trial_sub[DIV_DW-1:0] : trial[DIV_DW-1:0];
      q_d    = {q_q[30:0], ge};
      ovf_d  = ovf_q | q_q[31];
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == DIV_LW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      d_q <= d_i;
    end
    n_q   <= n_d;
    rem_q <= rem_d;
    q_q   <= q_d;
    ovf_q <= ovf_d;
  end

  assign q_o    = q_q;
  assign ovf_o  = ovf_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

@@ hw/rtl/differential_drive_odometry.sv @@
// ----------------------------------------------------------------------------
// Differential-drive wheel odometry
// Encoder deltas to heading, position, travel and velocities, bit-serial.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// s_axis    in   left_count, right_count, elapsed_us
// m_axis    out  pos_x, pos_y, heading, travelled, vel_x, vel_y, vel_turn
// cfg       in   meters_per_tick, inverse_wheel_base, left/right start count
//
// One item runs eight products on the shift-add multiplier (one bit a
// cycle), four passes of the restoring divider (one quotient bit a cycle)
// and the CORDIC rotation, one CORDIC iteration a cycle.
// Reset clears the accumulators and loads the default scale registers.
// A finished result waits in the output register; the next item is taken
// meanwhile and only stalls at its end if that register is still full.
// ----------------------------------------------------------------------------
`include "differential_drive_odometry_assert.svh"

module differential_drive_odometry #(
  parameter int unsigned CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [55:0]  s_axis_tdata,  // left_count, right_count, elapsed_us
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [223:0] m_axis_tdata   // pos_x, pos_y, heading, travelled,
                                      // vel_x, vel_y, vel_turn
);
  import ddo_pkg::*;

  localparam int unsigned ITW = $clog2(CORDIC_STEPS + 1);

  localparam logic [1:0] REG_MPT    = 2'd0;
  localparam logic [1:0] REG_IBW    = 2'd1;
  localparam logic [1:0] REG_LSTART = 2'd2;
  localparam logic [1:0] REG_RSTART = 2'd3;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MANG1 = 4'd1;
  localparam logic [3:0] ST_MANG2 = 4'd2;
  localparam logic [3:0] ST_MSTEP = 4'd3;
  localparam logic [3:0] ST_WRAP  = 4'd4;
  localparam logic [3:0] ST_ROT   = 4'd5;
  localparam logic [3:0] ST_MX    = 4'd6;
  localparam logic [3:0] ST_MY    = 4'd7;
  localparam logic [3:0] ST_MVT   = 4'd8;
  localparam logic [3:0] ST_DVT   = 4'd9;
  localparam logic [3:0] ST_MVX   = 4'd10;
  localparam logic [3:0] ST_DVX   = 4'd11;
  localparam logic [3:0] ST_MVY   = 4'd12;
  localparam logic [3:0] ST_DVY   = 4'd13;
  localparam logic [3:0] ST_DONE  = 4'd14;

  logic [3:0]  state_q, state_d;
  logic        run_q, run_d;
  logic [15:0] last_l_q, last_l_d, last_r_q, last_r_d;
  logic [31:0] mpt_q, mpt_d, ibw_q, ibw_d;
  logic [31:0] x_q, x_d, y_q, y_d, ang_q, ang_d, dist_q, dist_d;
  logic [31:0] old_x_q, old_x_d, old_y_q, old_y_d;
  logic signed [17:0] diff_q, diff_d, sum_q, sum_d;
  logic [23:0] us_q, us_d;
  logic [52:0] dang_mag_q, dang_mag_d;
  logic        dang_neg_q, dang_neg_d;
  logic [31:0] step_mag_q, step_mag_d;
  logic        step_neg_q, step_neg_d;
  logic signed [33:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic        flip_q, flip_d;
  logic [ITW-1:0] it_q, it_d;
  logic [31:0] vx_q, vx_d, vy_q, vy_d, vt_q, vt_d;
  logic        out_valid_q, out_valid_d;
  logic [223:0] out_data_q, out_data_d;

  // unit interface
  logic               mul_start, mul_done;
  logic [MUL_AW-1:0]  mul_a;
  logic [MUL_BW-1:0]  mul_b;
  logic [MUL_PW-1:0]  mul_prod;
  logic               div_start;
  ddo_div_ctl_t       div_ctl;
  logic [DIV_NW-1:0]  div_n;
  logic [DIV_DW-1:0]  div_d;
  logic [31:0]        div_q;
  logic               div_ovf, div_done;
  logic [DIV_DW-1:0]  div_rem;

  // datapath helpers
  logic signed [15:0] dl, dr;
  logic [17:0]        diff_mag, sum_mag;
  logic signed [55:0] dang_s, v_ang;
  logic [55:0]        v_mag;
  logic signed [33:0] rs, rw;
  logic signed [33:0] h0, h1;
  logic               h_flip;
  logic signed [33:0] xs, ys, at;
  logic [33:0]        cx_mag, cy_mag;
  logic [31:0]        pmag;
  logic               pneg;
  logic signed [33:0] pstep, step_s;
  logic signed [32:0] dx, dy;
  logic [32:0]        dx_mag, dy_mag;

  assign dl       = s_axis_tdata[15:0] - last_l_q;
  assign dr       = s_axis_tdata[31:16] - last_r_q;
  assign diff_mag = diff_q[17] ? 18'(-diff_q) : diff_q;
  assign sum_mag  = sum_q[17] ? 18'(-sum_q) : sum_q;

  assign dang_s = dang_neg_q ? -{3'b0, dang_mag_q} : {3'b0, dang_mag_q};
  assign v_ang  = {{24{ang_q[31]}}, ang_q} + dang_s;
  assign v_mag  = v_ang[55] ? 56'(-v_ang) : v_ang;
  assign rs     = v_ang[55] ? -{2'b0, div_rem[31:0]} : {2'b0, div_rem[31:0]};

  always_comb begin
    rw = rs;
    if (rs > PI_Q29) begin
      rw = rs - TWO_PI_Q29;
    end else if (rs < -PI_Q29) begin
      rw = rs + TWO_PI_Q29;
    end
  end

  assign h0 = {{2{ang_q[31]}}, ang_q};
  always_comb begin
    h1     = h0;
    h_flip = 1'b0;
    if (h0 > HALF_PI_Q29) begin
      h1     = h0 - PI_Q29;
      h_flip = 1'b1;
    end else if (h0 < -HALF_PI_Q29) begin
      h1     = h0 + PI_Q29;
      h_flip = 1'b1;
    end
  end

  assign xs     = cx_q >>> it_q;
  assign ys     = cy_q >>> it_q;
  assign at     = {3'b0, atan_q30(5'(it_q))};
  assign cx_mag = cx_q[33] ? 34'(-cx_q) : cx_q;
  assign cy_mag = cy_q[33] ? 34'(-cy_q) : cy_q;

  assign pmag   = mul_prod[61:30];
  assign pneg   = step_neg_q ^ ((state_q == ST_MY) ? cy_q[33] : cx_q[33]);
  assign pstep  = pneg ? -{2'b0, pmag} : {2'b0, pmag};
  assign step_s = sum_q[17] ? -{2'b0, mul_prod[48:17]} : {2'b0, mul_prod[48:17]};

  assign dx     = {x_q[31], x_q} - {old_x_q[31], old_x_q};
  assign dy     = {y_q[31], y_q} - {old_y_q[31], old_y_q};
  assign dx_mag = dx[32] ? 33'(-dx) : dx;
  assign dy_mag = dy[32] ? 33'(-dy) : dy;

  // operand selection for the shared units
  always_comb begin
    mul_a = '0;
    mul_b = US_PER_SECOND;
    case (state_q)
      ST_MANG1: begin
        mul_a = MUL_AW'(diff_mag);
        mul_b = mpt_q;
      end
      ST_MANG2: begin
        mul_a = mul_prod[MUL_AW-1:0];
        mul_b = ibw_q;
      end
      ST_MSTEP: begin
        mul_a = MUL_AW'(sum_mag);
        mul_b = mpt_q;
      end
      ST_MX: begin
        mul_a = MUL_AW'(step_mag_q);
        mul_b = cx_mag[31:0];
      end
      ST_MY: begin
        mul_a = MUL_AW'(step_mag_q);
        mul_b = cy_mag[31:0];
      end
      ST_MVT:  mul_a = MUL_AW'(dang_mag_q);
      ST_MVX:  mul_a = MUL_AW'(dx_mag[31:0]);
      ST_MVY:  mul_a = MUL_AW'(dy_mag[31:0]);
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    div_ctl.start = div_start;
    div_n   = {mul_prod[52:0], 20'b0};
    div_d   = {13'b0, us_q};
    div_ctl.len = DIV_LW'(53);
    case (state_q)
      ST_WRAP: begin
        div_n       = {v_mag[53:0], 19'b0};
        div_d       = {5'b0, TWO_PI_Q29[31:0]};
        div_ctl.len = DIV_LW'(54);
      end
      ST_DVT: begin
        div_n       = mul_prod[72:0];
        div_d       = {us_q, 13'b0};
        div_ctl.len = DIV_LW'(73);
      end
      default: div_ctl.len = DIV_LW'(53);
    endcase
  end

  always_comb begin
    state_d     = state_q;
    run_d       = run_q;
    last_l_d    = last_l_q;
    last_r_d    = last_r_q;
    mpt_d       = mpt_q;
    ibw_d       = ibw_q;
    x_d         = x_q;
    y_d         = y_q;
    ang_d       = ang_q;
    dist_d      = dist_q;
    old_x_d     = old_x_q;
    old_y_d     = old_y_q;
    diff_d      = diff_q;
    sum_d       = sum_q;
    us_d        = us_q;
    dang_mag_d  = dang_mag_q;
    dang_neg_d  = dang_neg_q;
    step_mag_d  = step_mag_q;
    step_neg_d  = step_neg_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cz_d        = cz_q;
    flip_d      = flip_q;
    it_d        = it_q;
    vx_d        = vx_q;
    vy_d        = vy_q;
    vt_d        = vt_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    mul_start   = 1'b0;
    div_start   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          diff_d   = {{2{dr[15]}}, dr} - {{2{dl[15]}}, dl};
          sum_d    = {{2{dr[15]}}, dr} + {{2{dl[15]}}, dl};
          us_d     = (s_axis_tdata[55:32] == '0) ? 24'd1 : s_axis_tdata[55:32];
          last_l_d = s_axis_tdata[15:0];
          last_r_d = s_axis_tdata[31:16];
          state_d  = ST_MANG1;
        end
      end
      ST_MANG1, ST_MANG2, ST_MSTEP, ST_MX, ST_MY, ST_MVT, ST_MVX, ST_MVY: begin
        if (!run_q) begin
          mul_start = 1'b1;
          run_d     = 1'b1;
        end else if (mul_done) begin
          run_d = 1'b0;
          case (state_q)
            ST_MANG1: state_d = ST_MANG2;
            ST_MANG2: begin
              dang_mag_d = mul_prod[79:27];
              dang_neg_d = diff_q[17];
              state_d    = ST_MSTEP;
            end
            ST_MSTEP: begin
              step_mag_d = mul_prod[48:17];
              step_neg_d = sum_q[17];
              dist_d     = sat34({{2{dist_q[31]}}, dist_q} + step_s);
              state_d    = ST_WRAP;
            end
            ST_MX: begin
              old_x_d = x_q;
              x_d     = sat34({{2{x_q[31]}}, x_q} + pstep);
              state_d = ST_MY;
            end
            ST_MY: begin
              old_y_d = y_q;
              y_d     = sat34({{2{y_q[31]}}, y_q} + pstep);
              state_d = ST_MVT;
            end
            ST_MVT:  state_d = ST_DVT;
            ST_MVX:  state_d = ST_DVX;
            default: state_d = ST_DVY;
          endcase
        end
      end
      ST_WRAP, ST_DVT, ST_DVX, ST_DVY: begin
        if (!run_q) begin
          div_start = 1'b1;
          run_d     = 1'b1;
        end else if (div_done) begin
          run_d = 1'b0;
          case (state_q)
            ST_WRAP: begin
              ang_d   = rw[31:0];
              state_d = ST_ROT;
            end
            ST_DVT: begin
              vt_d    = rate_sat(dang_neg_q, div_ovf, div_q);
              state_d = ST_MVX;
            end
            ST_DVX: begin
              vx_d    = rate_sat(dx[32], div_ovf, div_q);
              state_d = ST_MVY;
            end
            default: begin
              vy_d    = rate_sat(dy[32], div_ovf, div_q);
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_ROT: begin
        if (!run_q) begin
          cx_d   = CORDIC_START_Q30;
          cy_d   = '0;
          cz_d   = h1 <<< 1;
          flip_d = h_flip;
          it_d   = '0;
          run_d  = 1'b1;
        end else if (it_q != ITW'(CORDIC_STEPS)) begin
          if (!cz_q[33]) begin
            cx_d = cx_q - ys;
            cy_d = cy_q + xs;
            cz_d = cz_q - at;
          end else begin
            cx_d = cx_q + ys;
            cy_d = cy_q - xs;
            cz_d = cz_q + at;
          end
          it_d = it_q + 1'b1;
        end else begin
          if (flip_q) begin
            cx_d = -cx_q;
            cy_d = -cy_q;
          end
          run_d   = 1'b0;
          state_d = ST_MX;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {vt_q, vy_q, vx_q, dist_q, ang_q, y_q, x_q};
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_MPT:    mpt_d    = cfg_wdata_i;
        REG_IBW:    ibw_d    = cfg_wdata_i;
        REG_LSTART: last_l_d = cfg_wdata_i[15:0];
        REG_RSTART: last_r_d = cfg_wdata_i[15:0];
        default:    mpt_d    = mpt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_q       <= 1'b0;
      last_l_q    <= '0;
      last_r_q    <= '0;
      mpt_q       <= MPT_RESET;
      ibw_q       <= IBW_RESET;
      x_q         <= '0;
      y_q         <= '0;
      ang_q       <= '0;
      dist_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      last_l_q    <= last_l_d;
      last_r_q    <= last_r_d;
      mpt_q       <= mpt_d;
      ibw_q       <= ibw_d;
      x_q         <= x_d;
      y_q         <= y_d;
      ang_q       <= ang_d;
      dist_q      <= dist_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    old_x_q    <= old_x_d;
    old_y_q    <= old_y_d;
    diff_q     <= diff_d;
    sum_q      <= sum_d;
    us_q       <= us_d;
    dang_mag_q <= dang_mag_d;
    dang_neg_q <= dang_neg_d;
    step_mag_q <= step_mag_d;
    step_neg_q <= step_neg_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    cz_q       <= cz_d;
    flip_q     <= flip_d;
    it_q       <= it_d;
    vx_q       <= vx_d;
    vy_q       <= vy_d;
    vt_q       <= vt_d;
    out_data_q <= out_data_d;
  end

  ddo_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (mul_prod),
    .done_o  (mul_done)
  );

  ddo_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .n_i    (div_n),
    .d_i    (div_d),
    .q_o    (div_q),
    .ovf_o  (div_ovf),
    .rem_o  (div_rem),
    .done_o (div_done)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `ODO_ASSERT_NXT(a_accept_leaves_idle, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `ODO_ASSERT_IMP(a_heading_range, 1'b1, (h0 <= PI_Q29) && (h0 >= -PI_Q29))
  `ODO_ASSERT_IMP(a_units_exclusive, 1'b1, !(mul_done && div_done))
  `ODO_ASSERT_IMP(a_result_held, (state_q == ST_DONE) && out_valid_q && !m_axis_tready, state_d == ST_DONE)

endmodule
